// ===== rtl/mmst_pkg.sv =====
// Package for the multi-mode soft timer: field widths, codes, FSM states and
// the command and status structs between controller and datapath.
// No dependencies.
package mmst_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int OP_W = 3;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int FIELD_W = 16;
	localparam int PCT_W = 8;
	localparam int PCT_SCALE = 100;
	localparam int PCT_CAP = 200;
	localparam int QUOT_STEPS = 8;
	localparam int STEP_W = $clog2(QUOT_STEPS);

	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 3'd0,
		OP_START   = 3'd1,
		OP_RESTART = 3'd2,
		OP_STOP    = 3'd3,
		OP_FORCE   = 3'd4,
		OP_TAKE    = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STOPPED = 2'd0,
		ST_RUNNING = 2'd1,
		ST_EXPIRED = 2'd2
	} status_t;

	typedef enum logic [MODE_W-1:0] {
		MD_FREE     = 2'd0,
		MD_ONESHOT  = 2'd1,
		MD_PERIODIC = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_MUL  = 2'd1,
		FSM_DIV  = 2'd2,
		FSM_DONE = 2'd3
	} fsm_t;

	typedef struct packed {
		logic exec;
		logic mul;
		logic div;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_stat_t;

endpackage

// ===== rtl/mmst_if.sv =====
// Channel interfaces of the multi-mode soft timer: command requests, result
// requests and the configuration write channel. Depends on mmst_pkg.
interface mmst_cmd_if;
	import mmst_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [MODE_W-1:0]   start_mode;
	modport source (output valid, op, start_mode, input ready);
	modport sink (input valid, op, start_mode, output ready);
endinterface

interface mmst_res_if;
	import mmst_pkg::*;
	logic                valid;
	logic                ready;
	logic                event_taken;
	logic [STATUS_W-1:0] run_status;
	logic [MODE_W-1:0]   active_mode;
	logic [FIELD_W-1:0]  elapsed_ticks;
	logic [FIELD_W-1:0]  remaining_ticks;
	logic [FIELD_W-1:0]  active_limit;
	logic [PCT_W-1:0]    percent_done;
	modport source (output valid, event_taken, run_status, active_mode, elapsed_ticks,
		remaining_ticks, active_limit, percent_done, input ready);
	modport sink (input valid, event_taken, run_status, active_mode, elapsed_ticks,
		remaining_ticks, active_limit, percent_done, output ready);
endinterface

interface mmst_cfg_if;
	import mmst_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] timeout_ticks;
	modport source (output valid, timeout_ticks, input ready);
	modport sink (input valid, timeout_ticks, output ready);
endinterface

// ===== rtl/multi_mode_soft_timer.sv =====
// Top level of the multi-mode soft timer: joins controller and datapath to the
// command, result and configuration channels. Depends on mmst_pkg, mmst_if, mmst_ctrl, mmst_dp.
//
// The cmd channel takes one request per command (tick, start, restart, stop,
// force expiry, take event); each request yields exactly one request on res
// with the timer state after the command. The cfg channel writes the timeout
// limit, is always ready, and is meant to be written while no command is in flight.
// The command executes at the accepting edge; the MUL state then forms the count
// times 100 product, the DIV state runs the eight steps of the restoring divider
// that forms the percentage, and the DONE state loads the result register. One
// command is in flight at a time and the controller is ready again in the cycle
// after the load, so a new command is not taken before the last one is loaded.
// When the receiver stalls, the finished result waits in the result register
// while the next command is accepted and processed; that command waits before
// its load until the register is taken. Reset clears the count and limit, stops
// the timer in free running mode, sets the timeout to zero and drops res valid.
module multi_mode_soft_timer #(
	parameter int COUNT_BITS = mmst_pkg::COUNT_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mmst_cmd_if.sink  cmd,
	mmst_res_if.source res,
	mmst_cfg_if.sink  cfg
);
	import mmst_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	assign cfg.ready = 1'b1;

	mmst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	mmst_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.stat            (dp_stat),
		.op              (cmd.op),
		.start_mode      (cmd.start_mode),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.timeout_ticks),
		.event_taken     (res.event_taken),
		.run_status      (res.run_status),
		.active_mode     (res.active_mode),
		.elapsed_ticks   (res.elapsed_ticks),
		.remaining_ticks (res.remaining_ticks),
		.active_limit    (res.active_limit),
		.percent_done    (res.percent_done)
	);

endmodule

// ===== rtl/mmst_dp.sv =====
// Datapath of the multi-mode soft timer: timer state, command execution,
// the percent multiply and restoring divider, and the result register. Depends on mmst_pkg.
module mmst_dp #(
	parameter int COUNT_BITS = mmst_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmst_pkg::dp_cmd_t             cmd,
	output mmst_pkg::dp_stat_t            stat,
	input  logic [mmst_pkg::OP_W-1:0]     op,
	input  logic [mmst_pkg::MODE_W-1:0]   start_mode,
	input  logic                          cfg_we,
	input  logic [mmst_pkg::FIELD_W-1:0]  cfg_data,
	output logic                          event_taken,
	output logic [mmst_pkg::STATUS_W-1:0] run_status,
	output logic [mmst_pkg::MODE_W-1:0]   active_mode,
	output logic [mmst_pkg::FIELD_W-1:0]  elapsed_ticks,
	output logic [mmst_pkg::FIELD_W-1:0]  remaining_ticks,
	output logic [mmst_pkg::FIELD_W-1:0]  active_limit,
	output logic [mmst_pkg::PCT_W-1:0]    percent_done
);
	import mmst_pkg::*;

	localparam int PROD_W = COUNT_BITS + 7;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [FIELD_W-1:0]    timeout_q;
	logic [COUNT_BITS-1:0] tick_q, tick_d, inc;
	logic [COUNT_BITS-1:0] limit_q, limit_d;
	status_t               status_q, status_d;
	mode_t                 mode_q, mode_d;
	logic                  taken_q, taken_d;
	logic [PROD_W-1:0]     rem_q, dsr_q;
	logic [PCT_W-1:0]      quot_q;
	logic                  sat_q;
	logic [STEP_W-1:0]     step_q;
	logic                  ge;
	logic                  run_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_comb begin
		tick_d = tick_q;
		limit_d = limit_q;
		status_d = status_q;
		mode_d = mode_q;
		taken_d = 1'b0;
		inc = (tick_q != CNT_MAX) ? tick_q + COUNT_BITS'(1) : tick_q;
		unique case (op_t'(op))
			OP_TICK: begin
				if (status_q == ST_RUNNING && mode_q != MD_FREE) begin
					tick_d = inc;
					if (inc >= limit_q) begin
						if (mode_q == MD_PERIODIC) tick_d = '0;
						status_d = ST_EXPIRED;
					end
				end
			end
			OP_START: begin
				case (mode_t'(start_mode)) inside
					MD_FREE: begin
						tick_d = '0;
						status_d = ST_RUNNING;
						mode_d = MD_FREE;
					end
					MD_ONESHOT, MD_PERIODIC: begin
						limit_d = COUNT_BITS'(timeout_q);
						tick_d = '0;
						status_d = ST_RUNNING;
						mode_d = mode_t'(start_mode);
					end
					default: ;
				endcase
			end
			OP_RESTART: begin
				tick_d = '0;
				status_d = ST_RUNNING;
			end
			OP_STOP: begin
				status_d = ST_STOPPED;
				limit_d = '0;
			end
			OP_FORCE: status_d = ST_EXPIRED;
			OP_TAKE: begin
				if (status_q == ST_EXPIRED) begin
					taken_d = 1'b1;
					if (mode_q == MD_ONESHOT) begin
						status_d = ST_STOPPED;
						limit_d = '0;
					end else begin
						status_d = ST_RUNNING;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			limit_q <= '0;
			status_q <= ST_STOPPED;
			mode_q <= MD_FREE;
			taken_q <= 1'b0;
		end else if (cmd.exec) begin
			tick_q <= tick_d;
			limit_q <= limit_d;
			status_q <= status_d;
			mode_q <= mode_d;
			taken_q <= taken_d;
		end
	end

	assign ge = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.mul) begin
			step_q <= STEP_W'(QUOT_STEPS - 1);
		end else if (cmd.div) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	assign stat.div_last = (step_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q <= PROD_W'(tick_q) * PROD_W'(PCT_SCALE);
			dsr_q <= PROD_W'(limit_q) << (QUOT_STEPS - 1);
			sat_q <= ({1'b0, tick_q} >= {limit_q, 1'b0});
			quot_q <= '0;
		end else if (cmd.div) begin
			if (ge) rem_q <= rem_q - dsr_q;
			dsr_q <= dsr_q >> 1;
			quot_q <= {quot_q[PCT_W-2:0], ge};
		end
	end

	assign run_fin = (status_q == ST_RUNNING) && (mode_q != MD_FREE);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			event_taken <= taken_q;
			run_status <= status_q;
			active_mode <= mode_q;
			elapsed_ticks <= (status_q == ST_RUNNING) ? FIELD_W'(tick_q) : '0;
			remaining_ticks <= (run_fin && limit_q > tick_q) ?
				FIELD_W'(limit_q - tick_q) : '0;
			active_limit <= (mode_q != MD_FREE && status_q != ST_STOPPED) ?
				FIELD_W'(limit_q) : '0;
			percent_done <= run_fin ? (sat_q ? PCT_W'(PCT_CAP) : quot_q) : '0;
		end
	end

endmodule

// ===== rtl/mmst_ctrl.sv =====
// Controller of the multi-mode soft timer: sequences command execution, the
// percent multiply and divide steps, and the result handshake. Depends on mmst_pkg.
module mmst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mmst_pkg::dp_cmd_t  cmd,
	input  mmst_pkg::dp_stat_t stat
);
	import mmst_pkg::*;

	fsm_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.exec = 1'b1;
					state_d = FSM_MUL;
				end
			end
			FSM_MUL: begin
				cmd.mul = 1'b1;
				state_d = FSM_DIV;
			end
			FSM_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_last) state_d = FSM_DONE;
			end
			FSM_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/mmst_checker.sv =====
// Port-level checker for the multi-mode soft timer and its bind to the top level.
// Depends on mmst_pkg and multi_mode_soft_timer.
module mmst_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          event_taken,
	input logic [mmst_pkg::STATUS_W-1:0] run_status,
	input logic [mmst_pkg::MODE_W-1:0]   active_mode,
	input logic [mmst_pkg::FIELD_W-1:0]  remaining_ticks,
	input logic [mmst_pkg::PCT_W-1:0]    percent_done
);
	import mmst_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result request dropped before it was taken.");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(run_status) && $stable(percent_done))
		else $error("Result payload changed while stalled.");

	a_taken_not_expired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_taken |-> run_status != ST_EXPIRED)
		else $error("A taken event left the timer expired.");

	a_pct_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent_done <= PCT_W'(PCT_CAP))
		else $error("Percent complete exceeds its cap.");

	a_finite_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (remaining_ticks != '0 || percent_done != '0) |->
		run_status == ST_RUNNING && active_mode != MD_FREE)
		else $error("Finite-mode fields set while not running in a finite mode.");

endmodule

bind multi_mode_soft_timer mmst_checker u_mmst_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (res.valid),
	.out_ready       (res.ready),
	.event_taken     (res.event_taken),
	.run_status      (res.run_status),
	.active_mode     (res.active_mode),
	.remaining_ticks (res.remaining_ticks),
	.percent_done    (res.percent_done)
);
